@@ hdl/l3d_pkg.sv @@
`default_nettype none
package l3d_pkg;

    localparam int DIM_DEFAULT = 33;
    localparam int CORNERS = 8;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_PIXEL = 1'b1;

    typedef struct packed {
        logic               op;
        logic        [15:0] node_index;
        logic signed [15:0] node_red;
        logic signed [15:0] node_green;
        logic signed [15:0] node_blue;
        logic        [15:0] pixel_red;
        logic        [15:0] pixel_green;
        logic        [15:0] pixel_blue;
    } t_in_beat;

    typedef struct packed {
        logic signed [15:0] out_red;
        logic signed [15:0] out_green;
        logic signed [15:0] out_blue;
    } t_out_beat;

    typedef struct packed {
        logic       wr_en;
        logic [2:0] wr_bank;
        logic       rd_en;
        logic [2:0] par;
    } t_bank_ctl;

endpackage
`default_nettype wire

@@ hdl/l3d_front.sv @@
`default_nettype none
module l3d_front
    import l3d_pkg::*;
#(
    parameter int DIM = DIM_DEFAULT,
    parameter int AW  = 13
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_en,
    input  wire logic           i_valid,
    input  wire t_in_beat       i_beat,
    output t_bank_ctl           o_ctl,
    output logic [AW-1:0]       o_addr [CORNERS],
    output logic [AW-1:0]       o_waddr,
    output logic [47:0]         o_wdata,
    output logic [48:0]         o_weight [CORNERS]
);

    localparam int CW = $clog2(DIM);
    localparam int TW = 16 + CW;
    localparam int HALF = (DIM + 1) / 2;
    localparam longint unsigned RECIP_L = ((64'd1 << 32) + DIM - 1) / DIM;
    localparam logic [31:0] RECIP = 32'(RECIP_L);
    localparam logic [15:0] DIM16 = 16'(DIM);
    localparam logic [AW-1:0] HALF_A = AW'(HALF);
    localparam logic [AW-1:0] HALF2_A = AW'(HALF * HALF);
    localparam logic [CW-1:0] DM1 = CW'(DIM - 1);

    // Stage A
    logic           r_a_valid, r_a_op;
    logic [15:0]    r_a_idx, r_a_q1;
    logic [47:0]    r_a_data;
    logic [TW-1:0]  r_a_t [3];
    logic [47:0]    n_a_prod;
    logic [15:0]    n_comp [3];

    // Stage B
    logic           r_b_valid, r_b_op;
    logic [15:0]    r_b_q1, r_b_q2;
    logic [CW-1:0]  r_b_red;
    logic [47:0]    r_b_data;
    logic [CW-1:0]  r_b_cell [3];
    logic [15:0]    r_b_frac [3];
    logic [47:0]    n_b_prod;
    logic [15:0]    n_b_rem;

    // Stage C
    logic           r_c_valid, r_c_op, r_c_inrange;
    logic [CW-1:0]  r_c_coord [3];
    logic [47:0]    r_c_data;
    logic [AW-1:0]  r_c_addr [CORNERS];
    logic [2:0]     r_c_par;
    logic [33:0]    r_c_wrg [4];
    logic [16:0]    r_c_wb [2];
    logic [15:0]    n_c_rem;
    logic [AW-1:0]  n_c_addr [CORNERS];
    logic [16:0]    n_wlo [3];
    logic [16:0]    n_whi [3];
    logic [33:0]    n_c_wrg [4];

    // Stage D
    logic           r_d_valid, r_d_op, r_d_inrange;
    logic [2:0]     r_d_wbank;
    logic [AW-1:0]  r_d_waddr;
    logic [47:0]    r_d_data;
    logic [AW-1:0]  r_d_addr [CORNERS];
    logic [2:0]     r_d_par;
    logic [48:0]    r_d_w [CORNERS];
    logic [AW-1:0]  n_d_waddr;
    logic [48:0]    n_d_w [CORNERS];

    assign n_comp[0] = i_beat.pixel_red;
    assign n_comp[1] = i_beat.pixel_green;
    assign n_comp[2] = i_beat.pixel_blue;
    assign n_a_prod = {32'b0, i_beat.node_index} * {16'b0, RECIP};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_valid;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
            r_d_valid <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_op   <= i_beat.op;
            r_a_idx  <= i_beat.node_index;
            r_a_q1   <= n_a_prod[47:32];
            r_a_data <= {i_beat.node_red, i_beat.node_green, i_beat.node_blue};
            for (int a = 0; a < 3; a++) begin
                r_a_t[a] <= TW'({CW'(0), n_comp[a]} * {16'b0, DM1});
            end
        end
    end

    assign n_b_prod = {32'b0, r_a_q1} * {16'b0, RECIP};
    assign n_b_rem  = r_a_idx - 16'(r_a_q1 * DIM16);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b_op   <= r_a_op;
            r_b_q1   <= r_a_q1;
            r_b_q2   <= n_b_prod[47:32];
            r_b_red  <= n_b_rem[CW-1:0];
            r_b_data <= r_a_data;
            for (int a = 0; a < 3; a++) begin
                r_b_cell[a] <= r_a_t[a][TW-1:16];
                r_b_frac[a] <= r_a_t[a][15:0];
            end
        end
    end

    assign n_c_rem = r_b_q1 - 16'(r_b_q2 * DIM16);

    always_comb begin
        logic [CW-1:0] c;
        logic [AW-1:0] h [3];
        for (int j = 0; j < CORNERS; j++) begin
            for (int a = 0; a < 3; a++) begin
                c = r_b_cell[a] + CW'(((j >> a) & 1) ^ int'(r_b_cell[a][0]));
                h[a] = AW'(c >> 1);
            end
            n_c_addr[j] = h[0] + AW'(h[1] * HALF_A) + AW'(h[2] * HALF2_A);
        end
        for (int a = 0; a < 3; a++) begin
            n_whi[a] = {1'b0, r_b_frac[a]};
            n_wlo[a] = 17'h10000 - n_whi[a];
        end
        for (int m = 0; m < 4; m++) begin
            n_c_wrg[m] = {17'b0, (m & 1) != 0 ? n_whi[0] : n_wlo[0]}
                       * {17'b0, (m & 2) != 0 ? n_whi[1] : n_wlo[1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c_op       <= r_b_op;
            r_c_inrange  <= r_b_q2 < DIM16;
            r_c_coord[0] <= r_b_red;
            r_c_coord[1] <= n_c_rem[CW-1:0];
            r_c_coord[2] <= r_b_q2[CW-1:0];
            r_c_data     <= r_b_data;
            r_c_addr     <= n_c_addr;
            r_c_par      <= {r_b_cell[2][0], r_b_cell[1][0], r_b_cell[0][0]};
            r_c_wrg      <= n_c_wrg;
            r_c_wb[0]    <= n_wlo[2];
            r_c_wb[1]    <= n_whi[2];
        end
    end

    assign n_d_waddr = AW'(r_c_coord[0] >> 1)
                     + AW'(AW'(r_c_coord[1] >> 1) * HALF_A)
                     + AW'(AW'(r_c_coord[2] >> 1) * HALF2_A);

    always_comb begin
        for (int k = 0; k < CORNERS; k++) begin
            n_d_w[k] = {15'b0, r_c_wrg[k & 3]} * {32'b0, r_c_wb[(k >> 2) & 1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d_op      <= r_c_op;
            r_d_inrange <= r_c_inrange;
            r_d_wbank   <= {r_c_coord[2][0], r_c_coord[1][0], r_c_coord[0][0]};
            r_d_waddr   <= n_d_waddr;
            r_d_data    <= r_c_data;
            r_d_addr    <= r_c_addr;
            r_d_par     <= r_c_par;
            r_d_w       <= n_d_w;
        end
    end

    assign o_ctl.wr_en   = r_d_valid && (r_d_op == OP_WRITE) && r_d_inrange;
    assign o_ctl.wr_bank = r_d_wbank;
    assign o_ctl.rd_en   = r_d_valid && (r_d_op == OP_PIXEL);
    assign o_ctl.par     = r_d_par;
    assign o_addr   = r_d_addr;
    assign o_waddr  = r_d_waddr;
    assign o_wdata  = r_d_data;
    assign o_weight = r_d_w;

endmodule
`default_nettype wire

@@ hdl/l3d_bank.sv @@
`default_nettype none
module l3d_bank
    import l3d_pkg::*;
#(
    parameter int DEPTH = 4913,
    parameter int AW    = 13
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [47:0]   i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output logic [47:0]        o_rdata
);

    logic [47:0] mem [DEPTH];
    logic [47:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

@@ hdl/l3d_blend.sv @@
`default_nettype none
module l3d_blend
    import l3d_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_en,
    input  wire t_bank_ctl   i_ctl,
    input  wire logic [48:0] i_weight [CORNERS],
    input  wire logic [47:0] i_rdata [CORNERS],
    output logic             o_valid,
    output t_out_beat        o_beat
);

    logic        r_e_valid, r_f_valid, r_g_valid, r_h_valid, r_i_valid;
    logic [2:0]  r_e_par;
    logic [48:0] r_e_w [CORNERS];
    logic [63:0] r_f_p [3][CORNERS];
    logic [63:0] r_g_s [3][4];
    logic [63:0] r_h_s [3];
    t_out_beat   r_out;
    logic [63:0] n_f_p [3][CORNERS];
    logic [15:0] n_i_ch [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid <= 1'b0;
            r_f_valid <= 1'b0;
            r_g_valid <= 1'b0;
            r_h_valid <= 1'b0;
            r_i_valid <= 1'b0;
        end else if (i_en) begin
            r_e_valid <= i_ctl.rd_en;
            r_f_valid <= r_e_valid;
            r_g_valid <= r_f_valid;
            r_h_valid <= r_g_valid;
            r_i_valid <= r_h_valid;
        end
    end

    always_comb begin
        logic [15:0] u;
        for (int ch = 0; ch < 3; ch++) begin
            for (int k = 0; k < CORNERS; k++) begin
                u = i_rdata[3'(k) ^ r_e_par][(2 - ch) * 16 +: 16] ^ 16'h8000;
                n_f_p[ch][k] = {15'b0, r_e_w[k]} * {48'b0, u};
            end
        end
    end

    always_comb begin
        logic [64:0] t;
        for (int ch = 0; ch < 3; ch++) begin
            t = {1'b0, r_h_s[ch]} + 65'h0_8000_0000_0000;
            n_i_ch[ch] = (t[64:48] > 17'hFFFF) ? 16'h7FFF : (t[63:48] ^ 16'h8000);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_e_par <= i_ctl.par;
            r_e_w   <= i_weight;
            r_f_p   <= n_f_p;
            for (int ch = 0; ch < 3; ch++) begin
                for (int m = 0; m < 4; m++) begin
                    r_g_s[ch][m] <= r_f_p[ch][2 * m] + r_f_p[ch][2 * m + 1];
                end
                r_h_s[ch] <= (r_g_s[ch][0] + r_g_s[ch][1]) + (r_g_s[ch][2] + r_g_s[ch][3]);
            end
            r_out.out_red   <= n_i_ch[0];
            r_out.out_green <= n_i_ch[1];
            r_out.out_blue  <= n_i_ch[2];
        end
    end

    assign o_valid = r_i_valid;
    assign o_beat  = r_out;

endmodule
`default_nettype wire

@@ hdl/lut3d_trilinear_interp_core.sv @@
// Color 3D lookup table with trilinear interpolation.
// Input channel: i_valid / o_stall carrying i_beat. A beat with op = write stores
// one lattice node at node_index (red fastest); an index past the lattice is
// dropped. A beat with op = pixel returns one interpolated color on the output
// channel o_valid / i_stall carrying o_beat; write beats return nothing.
// The lattice sits in eight banks split by the parity of the three coordinates,
// so the eight corners of any cell are read together in the same cycle.
// One beat is accepted every cycle unless a result waits under i_stall. A node
// written by one beat is seen by a pixel beat accepted in the next cycle.
// The whole pipeline advances together; while a result waits under i_stall
// every stage holds and o_stall is raised, so nothing is lost or repeated.
// Reset clears the pipeline valid bits only. The lattice contents are
// undefined until written, and pixels must only touch written nodes.
`default_nettype none
module lut3d_trilinear_interp_core
    import l3d_pkg::*;
#(
    parameter int P_DIM = DIM_DEFAULT
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    output logic          o_stall,
    input  wire t_in_beat i_beat,
    output logic          o_valid,
    input  wire logic     i_stall,
    output t_out_beat     o_beat
);

    localparam int HALF  = (P_DIM + 1) / 2;
    localparam int DEPTH = HALF * HALF * HALF;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic        en;
    t_bank_ctl   ctl;
    logic [AW-1:0] addr [CORNERS];
    logic [AW-1:0] waddr;
    logic [47:0] wdata;
    logic [48:0] weight [CORNERS];
    logic [47:0] rdata [CORNERS];

    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    l3d_front #(.DIM(P_DIM), .AW(AW)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (i_valid),
        .i_beat   (i_beat),
        .o_ctl    (ctl),
        .o_addr   (addr),
        .o_waddr  (waddr),
        .o_wdata  (wdata),
        .o_weight (weight)
    );

    for (genvar j = 0; j < CORNERS; j++) begin : g_bank
        l3d_bank #(.DEPTH(DEPTH), .AW(AW)) u_bank (
            .i_clk   (i_clk),
            .i_we    (en && ctl.wr_en && (ctl.wr_bank == 3'(j))),
            .i_waddr (waddr),
            .i_wdata (wdata),
            .i_re    (en && ctl.rd_en),
            .i_raddr (addr[j]),
            .o_rdata (rdata[j])
        );
    end

    l3d_blend u_blend (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_ctl    (ctl),
        .i_weight (weight),
        .i_rdata  (rdata),
        .o_valid  (o_valid),
        .o_beat   (o_beat)
    );

endmodule
`default_nettype wire

@@ hdl/l3d_checker.sv @@
`default_nettype none
module l3d_checker
    import l3d_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      o_stall,
    input wire logic      o_valid,
    input wire logic      i_stall,
    input wire t_out_beat o_beat
);

    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("Result beat dropped while stalled.");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_beat))
        else $error("Result beat changed while stalled.");

    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |-> o_stall)
        else $error("Input accepted while the result is stalled.");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("Result valid after reset.");

endmodule

bind lut3d_trilinear_interp_core l3d_checker u_l3d_checker (.*);
`default_nettype wire

@@ dv/lut3d_trilinear_interp_core_tb.sv @@
`timescale 1ns / 1ps
module lut3d_trilinear_interp_core_tb;
    import l3d_pkg::*;

    localparam int LDIM = DIM_DEFAULT;
    localparam int NODES = LDIM * LDIM * LDIM;
    localparam int ITEMS = 850;

    class blend_checker;
        bit [15:0] lattice[NODES][3];
        t_out_beat colors_due[$];
        int mismatches;

        function new();
            mismatches = 0;
        endfunction

        function t_out_beat blend(t_in_beat b);
            t_out_beat r;
            longint unsigned t, sum, res, w;
            longint unsigned wt[3][2];
            int cidx[3];
            int addr;
            bit [15:0] comp[3];
            bit [15:0] ch[3];
            comp[0] = b.pixel_red;
            comp[1] = b.pixel_green;
            comp[2] = b.pixel_blue;
            for (int a = 0; a < 3; a++) begin
                t = longint'(comp[a]) * (LDIM - 1);
                cidx[a] = int'(t >> 16);
                wt[a][1] = t & 64'hFFFF;
                wt[a][0] = 64'd65536 - wt[a][1];
            end
            for (int c = 0; c < 3; c++) begin
                sum = 0;
                for (int k = 0; k < CORNERS; k++) begin
                    addr = cidx[0] + k[0] + (cidx[1] + k[1]) * LDIM
                         + (cidx[2] + k[2]) * LDIM * LDIM;
                    if (addr >= NODES) addr = NODES - 1;
                    w = wt[0][k[0]] * wt[1][k[1]] * wt[2][k[2]];
                    sum += w * longint'(lattice[addr][c] ^ 16'h8000);
                end
                res = (sum + (64'd1 << 47)) >> 48;
                if (res > 65535) res = 65535;
                ch[c] = res[15:0] ^ 16'h8000;
            end
            r.out_red = ch[0];
            r.out_green = ch[1];
            r.out_blue = ch[2];
            return r;
        endfunction

        function void note_beat(t_in_beat b);
            if (b.op == OP_WRITE) begin
                if (b.node_index < NODES) begin
                    lattice[b.node_index][0] = b.node_red;
                    lattice[b.node_index][1] = b.node_green;
                    lattice[b.node_index][2] = b.node_blue;
                end
            end else begin
                colors_due.push_back(blend(b));
            end
        endfunction

        task report_mismatch(string msg);
            $display("ERROR %0t: %s", $realtime, msg);
            mismatches++;
        endtask

        task check_color(t_out_beat got);
            t_out_beat want;
            if (colors_due.size() == 0) begin
                report_mismatch($sformatf("unexpected result %h", got));
                return;
            end
            want = colors_due.pop_front();
            if (got.out_red !== want.out_red)
                report_mismatch($sformatf("out_red %h, want %h", got.out_red, want.out_red));
            if (got.out_green !== want.out_green)
                report_mismatch($sformatf("out_green %h, want %h",
                                          got.out_green, want.out_green));
            if (got.out_blue !== want.out_blue)
                report_mismatch($sformatf("out_blue %h, want %h",
                                          got.out_blue, want.out_blue));
        endtask
    endclass

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      o_stall;
    t_in_beat  i_beat = '0;
    logic      o_valid;
    logic      i_stall = 1'b0;
    t_out_beat o_beat;

    blend_checker checker_h = new();
    bit written[NODES];
    bit idling = 1'b1;
    int sent = 0;

    lut3d_trilinear_interp_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_beat(i_beat), .o_valid(o_valid), .i_stall(i_stall), .o_beat(o_beat)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) checker_h.note_beat(i_beat);
            if (o_valid && !i_stall) checker_h.check_color(o_beat);
        end
    end

    always @(negedge i_clk) begin
        i_stall <= idling && ($urandom_range(99) < 28);
    end

    task automatic send_beat(t_in_beat b);
        while (idling && $urandom_range(99) < 28) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_beat <= b;
        do @(posedge i_clk); while (o_stall);
        sent++;
        @(negedge i_clk);
    endtask

    function automatic bit [15:0] node_value();
        case ($urandom_range(9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic write_node(int idx, bit [15:0] r, bit [15:0] g, bit [15:0] bl);
        t_in_beat b;
        b = '0;
        b.op = OP_WRITE;
        b.node_index = 16'(idx);
        b.node_red = r;
        b.node_green = g;
        b.node_blue = bl;
        b.pixel_red = 16'($urandom);
        b.pixel_green = 16'($urandom);
        b.pixel_blue = 16'($urandom);
        if (idx < NODES) written[idx] = 1'b1;
        send_beat(b);
    endtask

    task automatic send_pixel(bit [15:0] pr, bit [15:0] pg, bit [15:0] pb);
        t_in_beat b;
        int base, addr;
        base = int'((pr * (LDIM - 1)) >> 16) + int'((pg * (LDIM - 1)) >> 16) * LDIM
             + int'((pb * (LDIM - 1)) >> 16) * LDIM * LDIM;
        for (int k = 0; k < CORNERS; k++) begin
            addr = base + k[0] + k[1] * LDIM + k[2] * LDIM * LDIM;
            if (!written[addr]) write_node(addr, node_value(), node_value(), node_value());
        end
        b.op = OP_PIXEL;
        b.node_index = 16'($urandom);
        b.node_red = 16'($urandom);
        b.node_green = 16'($urandom);
        b.node_blue = 16'($urandom);
        b.pixel_red = pr;
        b.pixel_green = pg;
        b.pixel_blue = pb;
        send_beat(b);
    endtask

    function automatic bit [15:0] region_comp();
        return 16'($urandom_range(26623, 20480));
    endfunction

    initial begin
        int waited;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // First cell: red/green corners at opposite extremes, then edge pixels.
        for (int k = 0; k < CORNERS; k++)
            write_node(k[0] + k[1] * LDIM + k[2] * LDIM * LDIM,
                       k[0] ? 16'h7FFF : 16'h8000, k[1] ? 16'h8000 : 16'h7FFF,
                       k[2] ? 16'h7FFF : 16'h0000);
        send_pixel(16'h0000, 16'h0000, 16'h0000);
        send_pixel(16'h07FF, 16'h07FF, 16'h07FF);
        send_pixel(16'h0400, 16'h0001, 16'h07FE);
        write_node(NODES, 16'h1234, 16'h1234, 16'h1234);
        write_node(16'hFFFF, 16'h7FFF, 16'h8000, 16'h7FFF);
        send_pixel(16'h0000, 16'h0000, 16'h0000);
        send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
        write_node(NODES - 1, 16'h8000, 16'h8000, 16'h8000);
        send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_pixel(16'hFFFF, 16'h0000, 16'h8000);

        for (int n = 0; sent < ITEMS; n++) begin
            idling = !(n >= 100 && n < 220);
            case ($urandom_range(99)) inside
                [0:44]:  send_pixel(region_comp(), region_comp(), region_comp());
                [45:59]: send_pixel(16'($urandom), 16'($urandom), 16'($urandom));
                [60:89]: write_node($urandom_range(NODES - 1), node_value(),
                                    node_value(), node_value());
                default: write_node($urandom_range(65535), node_value(),
                                    node_value(), node_value());
            endcase
        end
        i_valid <= 1'b0;
        idling = 1'b1;

        waited = 0;
        while (checker_h.colors_due.size() != 0 && waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (30) @(posedge i_clk);
        if (checker_h.colors_due.size() == 0 && checker_h.mismatches == 0)
            $display("PASS lut3d_trilinear_interp_core");
        else
            $display("FAIL lut3d_trilinear_interp_core");
        $finish;
    end

    initial begin
        #10ms;
        $display("FAIL lut3d_trilinear_interp_core");
        $finish;
    end
endmodule
